### hdl/lgha_pkg.sv
package lgha_pkg;

    localparam int NUM_FEATURES_DEF = 4;
    localparam int NUM_CLUSTERS_DEF = 3;

    localparam int FEAT_SLOTS    = 4;
    localparam int CLUSTER_SLOTS = 2;
    localparam int FEAT_IDX_W    = 2;
    localparam int PARAM_W       = 3;

    localparam int X_W      = 16;
    localparam int PROB_W   = 17;
    localparam int SUM_W    = 64;
    localparam int MA_W     = 33;
    localparam int MB_W     = 22;
    localparam int PROD_W   = MA_W + MB_W;
    localparam int HOLD_W   = 37;
    localparam int PROB_ONE = 65536;

    localparam int GRAD_SHIFT = 8;
    localparam int HESS_SHIFT = 16;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL_A = 8'b0000_0010,
        ST_MUL_B = 8'b0000_0100,
        ST_MUL_C = 8'b0000_1000,
        ST_MUL_D = 8'b0001_0000,
        ST_ROUND = 8'b0010_0000,
        ST_ACC   = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } state_t;

    typedef enum logic {
        KIND_GRADIENT = 1'b0,
        KIND_HESSIAN  = 1'b1
    } kind_t;

    typedef struct packed {
        state_t                phase;
        kind_t                 kind;
        logic                  ca;
        logic                  cb;
        logic [FEAT_IDX_W-1:0] fi;
        logic [FEAT_IDX_W-1:0] fj;
    } ctl_t;

endpackage

### hdl/lgha_arith.sv
module lgha_arith
    import lgha_pkg::*;
(
    input  logic                     clk,
    input  ctl_t                     ctl,
    input  logic signed [X_W-1:0]    x [FEAT_SLOTS],
    input  logic        [PROB_W-1:0] post [CLUSTER_SLOTS],
    input  logic        [PROB_W-1:0] prior [CLUSTER_SLOTS],
    input  logic        [SUM_W-1:0]  acc_in,
    input  logic                     acc_valid,
    output logic        [SUM_W-1:0]  sum
);

    logic signed [MA_W-1:0]   ma;
    logic signed [MB_W-1:0]   mb;
    logic signed [PROD_W-1:0] prod_full;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [HOLD_W-1:0] hold_reg;
    logic signed [MB_W-1:0]   factor_reg;
    logic signed [SUM_W-1:0]  term_reg;

    logic signed [PROB_W:0]   delta;
    logic signed [PROB_W:0]   diff_g;
    logic signed [PROB_W:0]   prior_bd;
    logic signed [PROB_W:0]   post_bd;
    logic signed [HOLD_W:0]   inter;
    logic        [PROD_W:0]   rnd;
    logic        [SUM_W-1:0]  base;
    logic        [SUM_W:0]    wide;

    always_comb
    begin
        delta    = (ctl.ca == ctl.cb) ? (PROB_W + 1)'(PROB_ONE) : '0;
        diff_g   = $signed({1'b0, post[ctl.ca]}) - $signed({1'b0, prior[ctl.ca]});
        prior_bd = $signed({1'b0, prior[ctl.cb]}) - delta;
        post_bd  = $signed({1'b0, post[ctl.cb]}) - delta;
        ma = '0;
        mb = '0;
        case (ctl.phase)
            ST_MUL_A:
            begin
                if (ctl.kind == KIND_HESSIAN)
                begin
                    ma = MA_W'($signed({1'b0, prior[ctl.ca]}));
                    mb = MB_W'(prior_bd);
                end
                else
                begin
                    ma = MA_W'(x[ctl.fi]);
                    mb = MB_W'(diff_g);
                end
            end
            ST_MUL_B:
            begin
                ma = MA_W'($signed({1'b0, post[ctl.ca]}));
                mb = MB_W'(post_bd);
            end
            ST_MUL_C:
            begin
                ma = MA_W'(x[ctl.fi]);
                mb = MB_W'(x[ctl.fj]);
            end
            ST_MUL_D:
            begin
                ma = $signed(prod_reg[MA_W-1:0]);
                mb = factor_reg;
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign prod_full = ma * mb;

    assign inter = $signed({hold_reg[HOLD_W-1], hold_reg})
                 - $signed({prod_reg[HOLD_W-1], prod_reg[HOLD_W-1:0]});

    assign rnd = {prod_reg[PROD_W-1], prod_reg}
               + ((ctl.kind == KIND_HESSIAN) ? (PROD_W + 1)'(1 << (HESS_SHIFT - 1))
                                             : (PROD_W + 1)'(1 << (GRAD_SHIFT - 1)));

    always_ff @(posedge clk)
    begin
        if (ctl.phase == ST_MUL_A || ctl.phase == ST_MUL_B
            || ctl.phase == ST_MUL_C || ctl.phase == ST_MUL_D)
        begin
            prod_reg <= prod_full;
        end
        if (ctl.phase == ST_MUL_B)
        begin
            hold_reg <= prod_reg[HOLD_W-1:0] + HOLD_W'(1 << (HESS_SHIFT - 1));
        end
        if (ctl.phase == ST_MUL_C)
        begin
            factor_reg <= inter[HOLD_W:HESS_SHIFT];
        end
        if (ctl.phase == ST_ROUND)
        begin
            if (ctl.kind == KIND_HESSIAN)
            begin
                term_reg <= SUM_W'($signed(rnd[PROD_W:HESS_SHIFT]));
            end
            else
            begin
                term_reg <= SUM_W'($signed(rnd[PROD_W:GRAD_SHIFT]));
            end
        end
    end

    always_comb
    begin
        base = acc_valid ? acc_in : '0;
        wide = {base[SUM_W-1], base} + {term_reg[SUM_W-1], term_reg};
        if (wide[SUM_W] != wide[SUM_W-1])
        begin
            sum = wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
        end
        else
        begin
            sum = wide[SUM_W-1:0];
        end
    end

endmodule

### hdl/logit_gradient_hessian_accumulator_top.sv
// One shared 33 x 22 bit multiplier handles a data row entry by entry: every gradient
// entry takes one product, a rounding step and a read-modify-write of the accumulator
// memory, every Hessian entry four products, a rounding step and a read-modify-write.
// With P = NUM_FEATURES * (NUM_CLUSTERS - 1) parameters busy stays high through P
// gradient and P*(P+1)/2 Hessian entries; a new start is accepted once busy is low.
// On a row marked last_row the block then reads out and clears its P + P*(P+1)/2
// sums (44 by default), one per cycle; each result passes the read and emit registers
// and the output registers and is on the ports for exactly one cycle, marked by strobe.
// The receiver cannot stall this stream and must take every transfer as it comes.
module logit_gradient_hessian_accumulator_top
    import lgha_pkg::*;
#(
    parameter int NUM_FEATURES = NUM_FEATURES_DEF,
    parameter int NUM_CLUSTERS = NUM_CLUSTERS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [X_W-1:0]    feature_a,
    input  logic signed [X_W-1:0]    feature_b,
    input  logic signed [X_W-1:0]    feature_c,
    input  logic signed [X_W-1:0]    feature_d,
    input  logic        [PROB_W-1:0] posterior_one,
    input  logic        [PROB_W-1:0] posterior_two,
    input  logic        [PROB_W-1:0] prior_one,
    input  logic        [PROB_W-1:0] prior_two,
    input  logic                     last_row,
    output logic                     strobe,
    output logic signed [SUM_W-1:0]  sum_value,
    output logic                     entry_kind,
    output logic        [PARAM_W-1:0] row_param,
    output logic        [PARAM_W-1:0] col_param,
    output logic                     final_entry
);

    localparam int NUM_PARAMS  = NUM_FEATURES * (NUM_CLUSTERS - 1);
    localparam int NUM_PAIRS   = (NUM_PARAMS * (NUM_PARAMS + 1)) / 2;
    localparam int NUM_ENTRIES = NUM_PARAMS + NUM_PAIRS;
    localparam int ADDR_W      = $clog2(NUM_ENTRIES);

    localparam logic [FEAT_IDX_W-1:0] FEAT_LAST  = FEAT_IDX_W'(NUM_FEATURES - 1);
    localparam logic [PARAM_W-1:0]    PARAM_LAST = PARAM_W'(NUM_PARAMS - 1);
    localparam logic [ADDR_W-1:0]     ADDR_LAST  = ADDR_W'(NUM_ENTRIES - 1);

    state_t                state_reg, state_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    kind_t                 kind_reg, kind_next;
    logic [PARAM_W-1:0]    p_reg, p_next;
    logic [PARAM_W-1:0]    q_reg, q_next;
    logic                  ca_reg, ca_next;
    logic                  cb_reg, cb_next;
    logic [FEAT_IDX_W-1:0] fi_reg, fi_next;
    logic [FEAT_IDX_W-1:0] fj_reg, fj_next;

    kind_t                 adv_kind;
    logic [PARAM_W-1:0]    adv_p;
    logic [PARAM_W-1:0]    adv_q;
    logic                  adv_ca;
    logic                  adv_cb;
    logic [FEAT_IDX_W-1:0] adv_fi;
    logic [FEAT_IDX_W-1:0] adv_fj;
    logic                  step_ca;
    logic                  step_cb;
    logic [FEAT_IDX_W-1:0] step_fi;
    logic [FEAT_IDX_W-1:0] step_fj;

    logic signed [X_W-1:0] x_reg [FEAT_SLOTS];
    logic [PROB_W-1:0]     post_reg [CLUSTER_SLOTS];
    logic [PROB_W-1:0]     prior_reg [CLUSTER_SLOTS];
    logic                  last_row_reg;

    logic [SUM_W-1:0]      mem [NUM_ENTRIES];
    logic [SUM_W-1:0]      rd_reg;
    logic [NUM_ENTRIES-1:0] valid_reg;
    logic [SUM_W-1:0]      acc_sum;
    logic                  mem_we;
    ctl_t                  ctl;

    logic                  emit_strobe_reg;
    logic                  emit_valid_reg;
    kind_t                 emit_kind_reg;
    logic [PARAM_W-1:0]    emit_row_reg;
    logic [PARAM_W-1:0]    emit_col_reg;
    logic                  emit_final_reg;

    logic                  strobe_reg;
    logic [SUM_W-1:0]      sum_value_reg;
    kind_t                 entry_kind_reg;
    logic [PARAM_W-1:0]    row_param_reg;
    logic [PARAM_W-1:0]    col_param_reg;
    logic                  final_entry_reg;

    assign busy   = (state_reg != ST_IDLE);
    assign mem_we = (state_reg == ST_ACC);

    assign ctl = '{phase: state_reg, kind: kind_reg, ca: ca_reg, cb: cb_reg,
                   fi: fi_reg, fj: fj_reg};

    lgha_arith u_arith (
        .clk       (clk),
        .ctl       (ctl),
        .x         (x_reg),
        .post      (post_reg),
        .prior     (prior_reg),
        .acc_in    (rd_reg),
        .acc_valid (valid_reg[addr_reg]),
        .sum       (acc_sum)
    );

    // Walks the gradient entries first, then the upper triangle of the Hessian
    // in row-major order, in the same order as the accumulator addresses.
    always_comb
    begin
        if (fi_reg == FEAT_LAST)
        begin
            step_ca = ca_reg + 1'b1;
            step_fi = '0;
        end
        else
        begin
            step_ca = ca_reg;
            step_fi = fi_reg + 1'b1;
        end
        if (fj_reg == FEAT_LAST)
        begin
            step_cb = cb_reg + 1'b1;
            step_fj = '0;
        end
        else
        begin
            step_cb = cb_reg;
            step_fj = fj_reg + 1'b1;
        end
        adv_kind = kind_reg;
        adv_p    = p_reg;
        adv_q    = q_reg;
        adv_ca   = ca_reg;
        adv_cb   = cb_reg;
        adv_fi   = fi_reg;
        adv_fj   = fj_reg;
        if (kind_reg == KIND_GRADIENT)
        begin
            if (p_reg == PARAM_LAST)
            begin
                adv_kind = KIND_HESSIAN;
                adv_p    = '0;
                adv_q    = '0;
                adv_ca   = 1'b0;
                adv_cb   = 1'b0;
                adv_fi   = '0;
                adv_fj   = '0;
            end
            else
            begin
                adv_p  = p_reg + 1'b1;
                adv_ca = step_ca;
                adv_fi = step_fi;
            end
        end
        else if (q_reg == PARAM_LAST)
        begin
            adv_p  = p_reg + 1'b1;
            adv_ca = step_ca;
            adv_fi = step_fi;
            adv_q  = p_reg + 1'b1;
            adv_cb = step_ca;
            adv_fj = step_fi;
        end
        else
        begin
            adv_q  = q_reg + 1'b1;
            adv_cb = step_cb;
            adv_fj = step_fj;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        kind_next  = kind_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        ca_next    = ca_reg;
        cb_next    = cb_reg;
        fi_next    = fi_reg;
        fj_next    = fj_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MUL_A;
                    addr_next  = '0;
                    kind_next  = KIND_GRADIENT;
                    p_next     = '0;
                    q_next     = '0;
                    ca_next    = 1'b0;
                    cb_next    = 1'b0;
                    fi_next    = '0;
                    fj_next    = '0;
                end
            end
            ST_MUL_A:
            begin
                state_next = (kind_reg == KIND_HESSIAN) ? ST_MUL_B : ST_ROUND;
            end
            ST_MUL_B:
            begin
                state_next = ST_MUL_C;
            end
            ST_MUL_C:
            begin
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (addr_reg == ADDR_LAST)
                begin
                    state_next = last_row_reg ? ST_EMIT : ST_IDLE;
                    addr_next  = '0;
                    kind_next  = KIND_GRADIENT;
                    p_next     = '0;
                    q_next     = '0;
                    ca_next    = 1'b0;
                    cb_next    = 1'b0;
                    fi_next    = '0;
                    fj_next    = '0;
                end
                else
                begin
                    state_next = ST_MUL_A;
                    addr_next  = addr_reg + 1'b1;
                    kind_next  = adv_kind;
                    p_next     = adv_p;
                    q_next     = adv_q;
                    ca_next    = adv_ca;
                    cb_next    = adv_cb;
                    fi_next    = adv_fi;
                    fj_next    = adv_fj;
                end
            end
            ST_EMIT:
            begin
                if (addr_reg == ADDR_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                    kind_next = adv_kind;
                    p_next    = adv_p;
                    q_next    = adv_q;
                    ca_next   = adv_ca;
                    cb_next   = adv_cb;
                    fi_next   = adv_fi;
                    fj_next   = adv_fj;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            addr_reg        <= '0;
            kind_reg        <= KIND_GRADIENT;
            p_reg           <= '0;
            q_reg           <= '0;
            ca_reg          <= 1'b0;
            cb_reg          <= 1'b0;
            fi_reg          <= '0;
            fj_reg          <= '0;
            valid_reg       <= '0;
            emit_strobe_reg <= 1'b0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            addr_reg        <= addr_next;
            kind_reg        <= kind_next;
            p_reg           <= p_next;
            q_reg           <= q_next;
            ca_reg          <= ca_next;
            cb_reg          <= cb_next;
            fi_reg          <= fi_next;
            fj_reg          <= fj_next;
            emit_strobe_reg <= (state_reg == ST_EMIT);
            strobe_reg      <= emit_strobe_reg;
            if (state_reg == ST_ACC)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
            else if (state_reg == ST_EMIT)
            begin
                valid_reg[addr_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            x_reg[0]     <= feature_a;
            x_reg[1]     <= feature_b;
            x_reg[2]     <= feature_c;
            x_reg[3]     <= feature_d;
            post_reg[0]  <= posterior_one;
            post_reg[1]  <= posterior_two;
            prior_reg[0] <= prior_one;
            prior_reg[1] <= prior_two;
            last_row_reg <= last_row;
        end
        if (mem_we)
        begin
            mem[addr_reg] <= acc_sum;
        end
        rd_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        emit_valid_reg  <= valid_reg[addr_reg];
        emit_kind_reg   <= kind_reg;
        emit_row_reg    <= p_reg;
        emit_col_reg    <= (kind_reg == KIND_HESSIAN) ? q_reg : p_reg;
        emit_final_reg  <= (addr_reg == ADDR_LAST);
        sum_value_reg   <= emit_valid_reg ? rd_reg : '0;
        entry_kind_reg  <= emit_kind_reg;
        row_param_reg   <= emit_row_reg;
        col_param_reg   <= emit_col_reg;
        final_entry_reg <= emit_final_reg;
    end

    assign strobe      = strobe_reg;
    assign sum_value   = $signed(sum_value_reg);
    assign entry_kind  = entry_kind_reg;
    assign row_param   = row_param_reg;
    assign col_param   = col_param_reg;
    assign final_entry = strobe_reg && final_entry_reg;

    a_strobe_from_readout: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(state_reg == ST_EMIT, 2))
        else $error("Result strobe without a matching readout cycle.");

    a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg == ST_EMIT) && state_reg == ST_IDLE) |-> (valid_reg == '0))
        else $error("Accumulators not cleared after readout.");

    a_final_is_last_pair: assert property (@(posedge clk) disable iff (!rst_n)
        final_entry |-> (entry_kind && row_param == PARAM_LAST && col_param == PARAM_LAST))
        else $error("Final marker on an entry other than the last Hessian entry.");

    a_start_launches: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_MUL_A && addr_reg == '0))
        else $error("Accepted row did not start at the first accumulator.");

endmodule

### verif/logit_gradient_hessian_accumulator_top_tb.sv
module logit_gradient_hessian_accumulator_top_tb
    import lgha_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PARAMS   = NUM_FEATURES_DEF * (NUM_CLUSTERS_DEF - 1);
    localparam int RANDOM_ROWS  = 470;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;
    localparam int PROB_MAX     = (1 << PROB_W) - 1;

    typedef struct {
        logic signed [X_W-1:0] feat_a;
        logic signed [X_W-1:0] feat_b;
        logic signed [X_W-1:0] feat_c;
        logic signed [X_W-1:0] feat_d;
        logic [PROB_W-1:0]     post_one;
        logic [PROB_W-1:0]     post_two;
        logic [PROB_W-1:0]     prior_one;
        logic [PROB_W-1:0]     prior_two;
        logic                  end_of_set;
        logic                  drain_first;
    } row_t;

    typedef struct {
        logic signed [SUM_W-1:0] total;
        kind_t                   kind;
        logic [PARAM_W-1:0]      row_idx;
        logic [PARAM_W-1:0]      col_idx;
        logic                    closing;
    } sum_entry_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start;
    logic                     busy;
    logic signed [X_W-1:0]    feature_a;
    logic signed [X_W-1:0]    feature_b;
    logic signed [X_W-1:0]    feature_c;
    logic signed [X_W-1:0]    feature_d;
    logic        [PROB_W-1:0] posterior_one;
    logic        [PROB_W-1:0] posterior_two;
    logic        [PROB_W-1:0] prior_one;
    logic        [PROB_W-1:0] prior_two;
    logic                     last_row;
    logic                     strobe;
    logic signed [SUM_W-1:0]  sum_value;
    logic                     entry_kind;
    logic        [PARAM_W-1:0] row_param;
    logic        [PARAM_W-1:0] col_param;
    logic                     final_entry;

    row_t       pending_rows[$];
    sum_entry_t expected_sums[$];
    longint     grad_sums[NUM_PARAMS];
    longint     hess_sums[NUM_PARAMS * (NUM_PARAMS + 1) / 2];
    row_t       row_now;
    sum_entry_t sum_now;
    int         burst_left;
    int         gap_left;
    int         quiet_cycles;
    int         error_count;

    logit_gradient_hessian_accumulator_top uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .feature_a     (feature_a),
        .feature_b     (feature_b),
        .feature_c     (feature_c),
        .feature_d     (feature_d),
        .posterior_one (posterior_one),
        .posterior_two (posterior_two),
        .prior_one     (prior_one),
        .prior_two     (prior_two),
        .last_row      (last_row),
        .strobe        (strobe),
        .sum_value     (sum_value),
        .entry_kind    (entry_kind),
        .row_param     (row_param),
        .col_param     (col_param),
        .final_entry   (final_entry)
    );

    always #5 clk = ~clk;

    function automatic longint round_half_up(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint add_saturated(input longint a, input longint b);
        longint s;
        s = a + b;
        if (b > 0 && s < a)
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (b < 0 && s > a)
            return 64'sh8000_0000_0000_0000;
        return s;
    endfunction

    function automatic void clear_sums();
        foreach (grad_sums[i])
            grad_sums[i] = 0;
        foreach (hess_sums[i])
            hess_sums[i] = 0;
    endfunction

    // Adds one row into the sums; a closing row also queues the full readout.
    function automatic void accumulate_row(input row_t r);
        longint     x[FEAT_SLOTS];
        longint     post[CLUSTER_SLOTS];
        longint     prior[CLUSTER_SLOTS];
        longint     unity;
        longint     inter;
        longint     factor;
        longint     term;
        int         ca;
        int         cb;
        int         fi;
        int         fj;
        int         k;
        sum_entry_t e;
        x[0] = longint'(r.feat_a);
        x[1] = longint'(r.feat_b);
        x[2] = longint'(r.feat_c);
        x[3] = longint'(r.feat_d);
        post[0] = longint'(r.post_one);
        post[1] = longint'(r.post_two);
        prior[0] = longint'(r.prior_one);
        prior[1] = longint'(r.prior_two);
        for (int p = 0; p < NUM_PARAMS; p++)
        begin
            ca = p / NUM_FEATURES_DEF;
            fi = p % NUM_FEATURES_DEF;
            term = round_half_up(x[fi] * (post[ca] - prior[ca]), GRAD_SHIFT);
            grad_sums[p] = add_saturated(grad_sums[p], term);
        end
        k = 0;
        for (int p = 0; p < NUM_PARAMS; p++)
        begin
            ca = p / NUM_FEATURES_DEF;
            fi = p % NUM_FEATURES_DEF;
            for (int q = p; q < NUM_PARAMS; q++)
            begin
                cb = q / NUM_FEATURES_DEF;
                fj = q % NUM_FEATURES_DEF;
                unity = (ca == cb) ? longint'(PROB_ONE) : 0;
                inter = prior[ca] * (prior[cb] - unity) - post[ca] * (post[cb] - unity);
                factor = round_half_up(inter, HESS_SHIFT);
                term = round_half_up(x[fi] * x[fj] * factor, HESS_SHIFT);
                hess_sums[k] = add_saturated(hess_sums[k], term);
                k++;
            end
        end
        if (!r.end_of_set)
            return;
        for (int p = 0; p < NUM_PARAMS; p++)
        begin
            e.total = grad_sums[p];
            e.kind = KIND_GRADIENT;
            e.row_idx = PARAM_W'(p);
            e.col_idx = PARAM_W'(p);
            e.closing = 1'b0;
            expected_sums.push_back(e);
        end
        k = 0;
        for (int p = 0; p < NUM_PARAMS; p++)
        begin
            for (int q = p; q < NUM_PARAMS; q++)
            begin
                e.total = hess_sums[k];
                e.kind = KIND_HESSIAN;
                e.row_idx = PARAM_W'(p);
                e.col_idx = PARAM_W'(q);
                e.closing = (p == NUM_PARAMS - 1) && (q == NUM_PARAMS - 1);
                expected_sums.push_back(e);
                k++;
            end
        end
        clear_sums();
    endfunction

    function automatic row_t make_row(input logic [X_W-1:0] a, input logic [X_W-1:0] b,
                                      input logic [X_W-1:0] c, input logic [X_W-1:0] d,
                                      input int po1, input int po2, input int pr1,
                                      input int pr2, input logic closing,
                                      input logic drain = 1'b0);
        row_t r;
        r.feat_a = a;
        r.feat_b = b;
        r.feat_c = c;
        r.feat_d = d;
        r.post_one = PROB_W'(po1);
        r.post_two = PROB_W'(po2);
        r.prior_one = PROB_W'(pr1);
        r.prior_two = PROB_W'(pr2);
        r.end_of_set = closing;
        r.drain_first = drain;
        return r;
    endfunction

    function automatic logic [X_W-1:0] random_feature();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return X_W'(int'($urandom_range(0, 512)) - 256);
            default: return X_W'($urandom());
        endcase
    endfunction

    function automatic int random_prob();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return PROB_ONE;
            2, 3: return $urandom_range(0, PROB_MAX);
            4: return $urandom_range(PROB_ONE + 1, PROB_MAX);
            default: return $urandom_range(0, PROB_ONE);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            feature_a <= '0;
            feature_b <= '0;
            feature_c <= '0;
            feature_d <= '0;
            posterior_one <= '0;
            posterior_two <= '0;
            prior_one <= '0;
            prior_two <= '0;
            last_row <= 1'b0;
            burst_left = $urandom_range(1, 12);
            gap_left = 0;
        end
        else
        begin
            if (start && !busy)
                accumulate_row(row_now);
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_rows.size() > 0 &&
                         !(pending_rows[0].drain_first && expected_sums.size() > 0))
                begin
                    row_now = pending_rows.pop_front();
                    feature_a <= row_now.feat_a;
                    feature_b <= row_now.feat_b;
                    feature_c <= row_now.feat_c;
                    feature_d <= row_now.feat_d;
                    posterior_one <= row_now.post_one;
                    posterior_two <= row_now.post_two;
                    prior_one <= row_now.prior_one;
                    prior_two <= row_now.prior_two;
                    last_row <= row_now.end_of_set;
                    start <= 1'b1;
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (expected_sums.size() == 0)
            begin
                $error("Result transfer with nothing expected: row %0d col %0d sum %0d",
                       row_param, col_param, sum_value);
                error_count++;
            end
            else
            begin
                sum_now = expected_sums.pop_front();
                if (sum_value !== sum_now.total)
                begin
                    $error("sum_value expected %0d actual %0d", sum_now.total, sum_value);
                    error_count++;
                end
                if (entry_kind !== sum_now.kind)
                begin
                    $error("entry_kind expected %0d actual %0d", sum_now.kind, entry_kind);
                    error_count++;
                end
                if (row_param !== sum_now.row_idx)
                begin
                    $error("row_param expected %0d actual %0d", sum_now.row_idx, row_param);
                    error_count++;
                end
                if (col_param !== sum_now.col_idx)
                begin
                    $error("col_param expected %0d actual %0d", sum_now.col_idx, col_param);
                    error_count++;
                end
                if (final_entry !== sum_now.closing)
                begin
                    $error("final_entry expected %0d actual %0d", sum_now.closing, final_entry);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int queued;
        int set_len;
        error_count = 0;
        quiet_cycles = 0;
        clear_sums();

        pending_rows.push_back(make_row(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                        0, 0, 0, 0, 1'b0));
        pending_rows.push_back(make_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                        PROB_ONE, PROB_ONE, 0, 0, 1'b0));
        pending_rows.push_back(make_row(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                        0, 0, PROB_ONE, PROB_ONE, 1'b0));
        pending_rows.push_back(make_row(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
                                        PROB_MAX, PROB_MAX, PROB_MAX, 0, 1'b1));
        pending_rows.push_back(make_row(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                        PROB_MAX, PROB_MAX, 0, 0, 1'b1));
        // Values chosen so that gradient terms land exactly halfway between codes.
        pending_rows.push_back(make_row(16'h0001, 16'hFFFF, 16'h0003, 16'hFFFD,
                                        128, 0, 0, 128, 1'b0));
        pending_rows.push_back(make_row(16'h0100, 16'hFF00, 16'h0080, 16'hFF80,
                                        32768, 32768, 32768, 32768, 1'b1));
        pending_rows.push_back(make_row(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                                        1, 65537, PROB_ONE + 1, 1, 1'b0));
        pending_rows.push_back(make_row(16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF,
                                        PROB_ONE, PROB_ONE, PROB_ONE, PROB_ONE, 1'b1));
        pending_rows.push_back(make_row(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                        PROB_MAX, 0, 0, PROB_MAX, 1'b1));

        queued = 0;
        while (queued < RANDOM_ROWS)
        begin
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                  : $urandom_range(1, 6);
            for (int i = 0; i < set_len; i++)
            begin
                pending_rows.push_back(make_row(random_feature(), random_feature(),
                                                random_feature(), random_feature(),
                                                random_prob(), random_prob(),
                                                random_prob(), random_prob(),
                                                i == set_len - 1,
                                                queued == 0 || $urandom_range(0, 39) == 0));
                queued++;
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_rows.size() != 0 || start || expected_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
